// File: sv/tted_pkg.sv
// Shared constants, operation codes and control types for the timeout table.
package tted_pkg;

  // Table geometry and field widths
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TIME_W  = 48;
  localparam int ID_W    = 32;
  localparam int FUNC_W  = 3;
  localparam int DL_W    = TIME_W - 1;

  // Largest signed time value
  localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

  // Operation codes; codes above FN_RESCHED only report status
  localparam logic [FUNC_W-1:0] FN_TICK      = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FN_SCHED_ABS = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FN_SCHED_REL = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] FN_CANCEL    = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] FN_QUERY     = FUNC_W'(4);
  localparam logic [FUNC_W-1:0] FN_RESCHED   = FUNC_W'(5);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;
    logic out_hold;
  } dp_stat_t;

endpackage

// File: sv/tted_if.sv
// Request and response channel interfaces for the timeout table.
interface tted_req_if;
  import tted_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [TIME_W-1:0] time_value;
  logic [ID_W-1:0]          timer_id;
  logic                     id_valid;

  modport source (output valid, func, time_value, timer_id, id_valid, input ready);
  modport sink   (input valid, func, time_value, timer_id, id_valid, output ready);
endinterface

interface tted_rsp_if;
  import tted_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   new_id;
  logic              found;
  logic              expired;
  logic              armed;
  logic [DL_W-1:0]   deadline;
  logic              table_full;

  modport source (output valid, new_id, found, expired, armed, deadline, table_full,
                  input ready);
  modport sink   (input valid, new_id, found, expired, armed, deadline, table_full,
                  output ready);
endinterface

// File: sv/timeout_table_earliest_deadline_core.sv
// Each request reads the entry table once, one entry per cycle through a registered
// read port, then commits; the next request is accepted only after that commit.
// The next request is accepted while a response waits; its commit then holds until taken.
// Reset (synchronous, active high) clears time, id counter and all in-use flags;
// the block accepts requests on the first cycle after reset.
module timeout_table_earliest_deadline_core (
  input  logic        clk,
  input  logic        rst,
  tted_req_if.sink    req,
  tted_rsp_if.source  rsp
);
  import tted_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tted_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tted_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_func       (req.func),
    .req_time_value (req.time_value),
    .req_timer_id   (req.timer_id),
    .req_id_valid   (req.id_valid),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_new_id     (rsp.new_id),
    .rsp_found      (rsp.found),
    .rsp_expired    (rsp.expired),
    .rsp_armed      (rsp.armed),
    .rsp_deadline   (rsp.deadline),
    .rsp_table_full (rsp.table_full)
  );

endmodule

// File: sv/tted_ctrl.sv
// Sequencer for the timeout table: accept, scan entries, drain read, commit.
module tted_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  tted_pkg::dp_stat_t   stat,
  output tted_pkg::ctrl_cmd_t  cmd
);
  import tted_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_hold) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    cmd.finish  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        cmd.finish = !stat.out_hold;
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_no_step_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !req_ready && !cmd.finish)
    else $error("scan step issued outside scan");
  a_drain_to_finish: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |=> state == ST_FINISH)
    else $error("drain did not lead to commit");
  a_capture_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.step)
    else $error("accepted request did not start a scan");

endmodule

// File: sv/tted_dp.sv
// Timeout table datapath: entry storage, scan pipeline, commit and result register.
module tted_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  tted_pkg::ctrl_cmd_t             cmd,
  output tted_pkg::dp_stat_t              stat,
  input  logic [tted_pkg::FUNC_W-1:0]     req_func,
  input  logic signed [tted_pkg::TIME_W-1:0] req_time_value,
  input  logic [tted_pkg::ID_W-1:0]       req_timer_id,
  input  logic                            req_id_valid,
  input  logic                            rsp_ready,
  output logic                            rsp_valid,
  output logic [tted_pkg::ID_W-1:0]       rsp_new_id,
  output logic                            rsp_found,
  output logic                            rsp_expired,
  output logic                            rsp_armed,
  output logic [tted_pkg::DL_W-1:0]       rsp_deadline,
  output logic                            rsp_table_full
);
  import tted_pkg::*;

  // Captured request
  logic [FUNC_W-1:0]        func_q;
  logic signed [TIME_W-1:0] tv_q;
  logic [ID_W-1:0]          tid_q;
  logic                     idv_q;

  // Persistent state
  logic signed [TIME_W-1:0] cur_time;
  logic [ID_W-1:0]          id_counter;
  logic [ENTRIES-1:0]       used;
  logic [ENTRIES-1:0]       used_next;
  logic [ID_W-1:0]          ident_mem  [ENTRIES];
  logic signed [TIME_W-1:0] expiry_mem [ENTRIES];

  // Scan pipeline
  logic [IDX_W-1:0]         idx;
  logic                     rd_valid;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_used;
  logic [ID_W-1:0]          rd_ident;
  logic signed [TIME_W-1:0] rd_expiry;

  // Scan results
  logic                     match_found;
  logic [IDX_W-1:0]         match_idx;
  logic signed [TIME_W-1:0] match_exp;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic                     min_valid;
  logic signed [TIME_W-1:0] min_exp;
  logic signed [TIME_W-1:0] sched_exp;

  // Combinational helpers
  logic [TIME_W-1:0]        add_sum;
  logic signed [TIME_W-1:0] add_sat;
  logic                     is_find;
  logic                     is_remove_op;
  logic                     hit;
  logic                     removes;
  logic                     sched_op;
  logic                     slot_ok;
  logic [IDX_W-1:0]         slot;
  logic                     sched_ok;
  logic                     fin_armed;
  logic signed [TIME_W-1:0] fin_min;
  logic [DL_W-1:0]          fin_deadline;
  logic                     fin_expired;

  // Status to the controller
  assign stat.scan_last = (idx == IDX_W'(ENTRIES - 1));
  assign stat.out_hold  = rsp_valid && !rsp_ready;

  // Saturating advance of the current time; non-positive deltas leave it unchanged
  assign add_sum = cur_time + tv_q;
  always_comb begin
    if (tv_q[TIME_W-1] || (tv_q == '0)) begin
      add_sat = cur_time;
    end else if (add_sum[TIME_W-1]) begin
      add_sat = TIME_MAX;
    end else begin
      add_sat = add_sum;
    end
  end

  // Classify the operation
  assign is_find      = (func_q == FN_CANCEL) || (func_q == FN_QUERY) ||
                        ((func_q == FN_RESCHED) && idv_q);
  assign is_remove_op = (func_q == FN_CANCEL) || (func_q == FN_RESCHED);
  assign sched_op     = (func_q == FN_SCHED_ABS) || (func_q == FN_SCHED_REL) ||
                        (func_q == FN_RESCHED);

  // First matching live entry in this scan
  assign hit = rd_valid && rd_used && (rd_ident == tid_q) && is_find && !match_found;

  // Commit decisions
  assign removes  = match_found && is_remove_op;
  assign slot_ok  = free_found || removes;
  assign slot     = (removes && (!free_found || (match_idx < free_idx))) ? match_idx
                                                                         : free_idx;
  assign sched_ok = sched_op && slot_ok;

  // Earliest expiry including the new entry, raised to one
  assign fin_armed = min_valid || sched_ok;
  assign fin_min   = (sched_ok && (!min_valid || (sched_exp < min_exp))) ? sched_exp
                                                                          : min_exp;
  always_comb begin
    if (!fin_armed) begin
      fin_deadline = '0;
    end else if (fin_min[TIME_W-1] || (fin_min == '0)) begin
      fin_deadline = DL_W'(1);
    end else begin
      fin_deadline = fin_min[DL_W-1:0];
    end
  end

  assign fin_expired = (func_q == FN_QUERY) && match_found && (cur_time > match_exp);

  // Next in-use flags: free the removed entry, then claim the new slot
  always_comb begin
    used_next = used;
    if (removes) begin
      used_next[match_idx] = 1'b0;
    end
    if (sched_ok) begin
      used_next[slot] = 1'b1;
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= req_func;
      tv_q   <= req_time_value;
      tid_q  <= req_timer_id;
      idv_q  <= req_id_valid;
    end
  end

  // Advance scan index and register the entry read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.step;
    end
    if (cmd.capture) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + IDX_W'(1);
    end
    rd_idx    <= idx;
    rd_used   <= used[idx];
    rd_ident  <= ident_mem[idx];
    rd_expiry <= expiry_mem[idx];
  end

  // Accumulate match, free slot and minimum over the scan
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      min_valid   <= 1'b0;
    end else if (rd_valid) begin
      if (hit) begin
        match_found <= 1'b1;
        match_idx   <= rd_idx;
        match_exp   <= rd_expiry;
      end
      if (!rd_used && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      // drop the entry this operation removes
      if (rd_used && !(hit && is_remove_op)) begin
        if (!min_valid || (rd_expiry < min_exp)) begin
          min_exp <= rd_expiry;
        end
        min_valid <= 1'b1;
      end
    end
    if (cmd.step) begin
      sched_exp <= (func_q == FN_SCHED_ABS) ? tv_q : add_sat;
    end
  end

  // Commit table, time and id updates
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      cur_time   <= '0;
      id_counter <= '0;
    end else if (cmd.finish) begin
      used <= used_next;
      if (sched_ok) begin
        id_counter <= id_counter + ID_W'(1);
      end
      if (func_q == FN_TICK) begin
        cur_time <= sched_exp;
      end
    end
  end

  // Entry storage writes
  always_ff @(posedge clk) begin
    if (cmd.finish && sched_ok) begin
      ident_mem[slot]  <= id_counter;
      expiry_mem[slot] <= sched_exp;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.finish) begin
      rsp_new_id     <= sched_ok ? id_counter : '0;
      rsp_found      <= match_found;
      rsp_expired    <= fin_expired;
      rsp_armed      <= fin_armed;
      rsp_deadline   <= fin_deadline;
      rsp_table_full <= sched_op && !slot_ok;
    end
  end

  // Checks
  a_full_no_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_table_full |-> rsp_new_id == '0)
    else $error("refused schedule reported an id");
  a_expired_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_expired |-> rsp_found)
    else $error("expired without a matching entry");
  a_armed_deadline: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_armed == (rsp_deadline != '0)))
    else $error("deadline disagrees with armed");
  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && sched_ok |=> id_counter == $past(id_counter) + ID_W'(1))
    else $error("id counter did not advance on schedule");

endmodule
